### rtl/point_colour_vote_classifier_core_defines.svh
// assertion macros shared by the colour vote classifier rtl
`ifndef POINT_COLOUR_VOTE_CLASSIFIER_CORE_DEFINES_SVH
`define POINT_COLOUR_VOTE_CLASSIFIER_CORE_DEFINES_SVH
`ifndef SYNTH
// property checked on every rising clk edge outside reset
`define PCVC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcvc assertion failed");
// condition that must never be true
`define PCVC_NEVER(label, cond) \
    `PCVC_ASSERT(label, !(cond))
`else
`define PCVC_ASSERT(label, prop)
`define PCVC_NEVER(label, cond)
`endif
`endif

### rtl/pcvc_pkg.sv
// shared types, constants and codes of the colour vote classifier
`timescale 1ns / 1ps
`default_nettype none
package pcvc_pkg;

    // field widths
    localparam int COORD_W  = 20;
    localparam int HALF_W   = 19;
    localparam int CHAN_W   = 8;
    localparam int THR_W    = 18;
    localparam int VOTE_W   = 21;
    localparam int SQ_W     = 18;
    localparam int DIST_W   = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 72;

    // vote counter saturation
    localparam int MAX_POINTS = 1048576;
    localparam logic [VOTE_W-1:0] VOTE_CAP =
        VOTE_W'((MAX_POINTS < 2097151) ? MAX_POINTS : 2097151);

    // colour targets at twice scale
    localparam logic signed [10:0] TGT_HI = 11'sd408;
    localparam logic signed [10:0] TGT_LO = 11'sd51;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_HALF_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_Z_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_Z_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTES   = 3'd6;

    // register reset values
    localparam logic signed [COORD_W-1:0] RST_CENTRE_X    = 20'sd0;
    localparam logic signed [COORD_W-1:0] RST_CENTRE_Y    = 20'sd0;
    localparam logic        [HALF_W-1:0]  RST_CROP_HALF_W = 19'd246;
    localparam logic signed [COORD_W-1:0] RST_CROP_Z_LOW  = -20'sd41;
    localparam logic signed [COORD_W-1:0] RST_CROP_Z_HIGH = 20'sd614;
    localparam logic        [THR_W-1:0]   RST_MATCH_THR   = 18'd6400;
    localparam logic        [VOTE_W-1:0]  RST_MIN_VOTES   = 21'd3;

    // colour codes
    typedef enum logic [1:0] {
        COL_NONE   = 2'd0,
        COL_RED    = 2'd1,
        COL_BLUE   = 2'd2,
        COL_PURPLE = 2'd3
    } colour_t;

    // configuration seen by front and back
    typedef struct packed {
        logic signed [COORD_W-1:0] centre_x;
        logic signed [COORD_W-1:0] centre_y;
        logic        [HALF_W-1:0]  crop_half_width;
        logic signed [COORD_W-1:0] crop_z_low;
        logic signed [COORD_W-1:0] crop_z_high;
        logic        [THR_W-1:0]   match_threshold_sq;
        logic        [VOTE_W-1:0]  min_votes;
    } cfg_t;

    // one classified point in the queue
    typedef struct packed {
        logic    vote;
        colour_t colour;
        logic    last;
    } qent_t;

    // queue handshake toward either side
    typedef struct packed {
        logic valid;
        logic full;
    } qstat_t;

endpackage
`default_nettype wire

### rtl/pcvc_front.sv
// front end: point accept, crop box test and nearest colour match
`timescale 1ns / 1ps
`default_nettype none
module pcvc_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire pcvc_pkg::cfg_t               cfg,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [pcvc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic                         s_axis_tuser,
    input  wire logic                         s_axis_tlast,
    input  wire pcvc_pkg::qstat_t             qstat,
    output logic                              push,
    output pcvc_pkg::qent_t                   push_ent
);
    import pcvc_pkg::*;

    logic signed [COORD_W-1:0] px, py, pz;
    logic [CHAN_W-1:0]         ch [3];
    logic signed [COORD_W+1:0] x_lo, x_hi, y_lo, y_hi, x_e, y_e;
    logic                      keep;
    logic [SQ_W-1:0]           sq_hi [3];
    logic [SQ_W-1:0]           sq_lo [3];
    logic signed [10:0]        e_hi, e_lo;
    logic signed [21:0]        p_hi, p_lo;

    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_keep_reg;
    logic                      s1_last_reg;
    logic [SQ_W-1:0]           s1_hi_reg [3];
    logic [SQ_W-1:0]           s1_lo_reg [3];

    logic [DIST_W-1:0]         d_red, d_blue, d_purple, d_best, thr4;
    colour_t                   best;
    logic                      advance;

    // unpack the request
    assign px    = s_axis_tdata[19:0];
    assign py    = s_axis_tdata[39:20];
    assign pz    = s_axis_tdata[59:40];
    assign ch[0] = s_axis_tdata[67:60];
    assign ch[1] = s_axis_tdata[75:68];
    assign ch[2] = s_axis_tdata[83:76];

    // inclusive crop box around the basket centre
    always_comb
    begin
        x_e  = COORD_W'(0) + {{2{px[COORD_W-1]}}, px};
        y_e  = {{2{py[COORD_W-1]}}, py};
        x_lo = {{2{cfg.centre_x[COORD_W-1]}}, cfg.centre_x} - {3'b000, cfg.crop_half_width};
        x_hi = {{2{cfg.centre_x[COORD_W-1]}}, cfg.centre_x} + {3'b000, cfg.crop_half_width};
        y_lo = {{2{cfg.centre_y[COORD_W-1]}}, cfg.centre_y} - {3'b000, cfg.crop_half_width};
        y_hi = {{2{cfg.centre_y[COORD_W-1]}}, cfg.centre_y} + {3'b000, cfg.crop_half_width};
        keep = s_axis_tuser
            && (x_e >= x_lo) && (x_e <= x_hi)
            && (y_e >= y_lo) && (y_e <= y_hi)
            && (pz >= cfg.crop_z_low) && (pz <= cfg.crop_z_high);
    end

    // squared channel errors against both target levels
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e_hi     = $signed({2'b00, ch[k], 1'b0}) - TGT_HI;
            e_lo     = $signed({2'b00, ch[k], 1'b0}) - TGT_LO;
            p_hi     = e_hi * e_hi;
            p_lo     = e_lo * e_lo;
            sq_hi[k] = p_hi[SQ_W-1:0];
            sq_lo[k] = p_lo[SQ_W-1:0];
        end
    end

    // stage one advances when empty or when its point enters the queue
    assign advance       = !s1_valid_reg || !qstat.full;
    assign s_axis_tready = advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (advance)
        begin
            s1_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s_axis_tvalid)
        begin
            s1_keep_reg <= keep;
            s1_last_reg <= s_axis_tlast;
            for (int k = 0; k < 3; k++)
            begin
                s1_hi_reg[k] <= sq_hi[k];
                s1_lo_reg[k] <= sq_lo[k];
            end
        end
    end

    // distances, nearest colour with the earlier one winning ties
    always_comb
    begin
        d_red    = {2'b00, s1_hi_reg[0]} + {2'b00, s1_lo_reg[1]} + {2'b00, s1_lo_reg[2]};
        d_blue   = {2'b00, s1_lo_reg[0]} + {2'b00, s1_lo_reg[1]} + {2'b00, s1_hi_reg[2]};
        d_purple = {2'b00, s1_hi_reg[0]} + {2'b00, s1_lo_reg[1]} + {2'b00, s1_hi_reg[2]};
        best     = COL_RED;
        d_best   = d_red;
        if (d_blue < d_best)
        begin
            best   = COL_BLUE;
            d_best = d_blue;
        end
        if (d_purple < d_best)
        begin
            best   = COL_PURPLE;
            d_best = d_purple;
        end
        thr4 = {cfg.match_threshold_sq, 2'b00};
    end

    // queue write
    assign push            = s1_valid_reg && !qstat.full;
    assign push_ent.vote   = s1_keep_reg && (d_best <= thr4);
    assign push_ent.colour = best;
    assign push_ent.last   = s1_last_reg;

endmodule
`default_nettype wire

### rtl/pcvc_queue.sv
// short fifo of classified points between front and back
`timescale 1ns / 1ps
`default_nettype none
`include "point_colour_vote_classifier_core_defines.svh"
module pcvc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pcvc_pkg::qent_t  push_ent,
    input  wire logic             pop,
    output pcvc_pkg::qent_t       pop_ent,
    output pcvc_pkg::qstat_t      qstat
);
    import pcvc_pkg::*;

    qent_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign qstat.valid = (count_reg != '0);
    assign qstat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_ent     = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_ent;
        end
    end

    `PCVC_NEVER(q_push_when_full, push && qstat.full && !pop)
    `PCVC_NEVER(q_pop_when_empty, pop && !qstat.valid)

endmodule
`default_nettype wire

### rtl/pcvc_back.sv
// back end: saturating vote counters, decision and output register
`timescale 1ns / 1ps
`default_nettype none
`include "point_colour_vote_classifier_core_defines.svh"
module pcvc_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pcvc_pkg::cfg_t                  cfg,
    input  wire pcvc_pkg::qstat_t                qstat,
    input  wire pcvc_pkg::qent_t                 pop_ent,
    output logic                                 pop,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [pcvc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import pcvc_pkg::*;

    logic [VOTE_W-1:0]       votes_reg [3];
    logic [VOTE_W-1:0]       votes_next [3];
    logic [VOTE_W-1:0]       upd [3];
    logic signed [VOTE_W:0]  best_v;
    colour_t                 code;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    decide;

    // a last point waits only for a free output register
    assign pop    = qstat.valid && (!pop_ent.last || !out_valid_reg || m_axis_tready);
    assign decide = pop && pop_ent.last;

    // counts including the popped point
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            upd[c] = votes_reg[c];
            if (pop && pop_ent.vote && (pop_ent.colour == colour_t'(c + 1))
                && (votes_reg[c] < VOTE_CAP))
            begin
                upd[c] = votes_reg[c] + 1'b1;
            end
            votes_next[c] = decide ? '0 : upd[c];
        end
    end

    // most votes at or above the minimum, earlier colour on ties
    always_comb
    begin
        best_v = $signed({1'b0, cfg.min_votes}) - $signed((VOTE_W+1)'(1));
        code   = COL_NONE;
        for (int c = 0; c < 3; c++)
        begin
            if ($signed({1'b0, upd[c]}) > best_v)
            begin
                best_v = $signed({1'b0, upd[c]});
                code   = colour_t'(c + 1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (decide)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                votes_reg[c] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < 3; c++)
            begin
                votes_reg[c] <= votes_next[c];
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (decide)
        begin
            out_data_reg <= {7'b0000000, upd[2], upd[1], upd[0], code};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `PCVC_ASSERT(bk_clear_after_last,
        decide |=> (votes_reg[0] == '0 && votes_reg[1] == '0 && votes_reg[2] == '0))
    `PCVC_NEVER(bk_over_cap,
        votes_reg[0] > VOTE_CAP || votes_reg[1] > VOTE_CAP || votes_reg[2] > VOTE_CAP)

endmodule
`default_nettype wire

### rtl/point_colour_vote_classifier_core.sv
// top level of the point colour vote classifier
// usage:
//  s_axis carries one point per request: tdata holds x, y, z (20 bit signed
//  each), then red, green, blue (8 bit); tuser is the finite flag, tlast marks
//  the last point of a basket's cloud.
//  m_axis carries one request per last point: colour code and the three
//  final vote counts. points that are not last give no result.
//  cfg_wr_en / cfg_index / cfg_data write one register per cycle; write
//  only while no point is in flight.
//  throughput: one point per cycle while the queue is not full, set by the
//  registered front stage and the counter update in the back end.
//  a last point passes the front stage register and the queue before its
//  result is registered, once the output register is free.
//  reset clears counters, queue and output; registers return to defaults.
//  when m_axis stalls, points keep flowing into the counters; a further last
//  point waits in the four entry queue, which then fills and lowers
//  s_axis_tready.
`timescale 1ns / 1ps
`default_nettype none
module point_colour_vote_classifier_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pcvc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pcvc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // point_x, point_y, point_z, red, green, blue, zero pad
    input  wire logic [pcvc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // finite
    input  wire logic                              s_axis_tuser,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // colour_code, red_votes, blue_votes, purple_votes, zero pad
    output logic [pcvc_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
    import pcvc_pkg::*;

    cfg_t   cfg_reg;
    qstat_t qstat;
    qent_t  push_ent, pop_ent;
    logic   push, pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre_x           <= RST_CENTRE_X;
            cfg_reg.centre_y           <= RST_CENTRE_Y;
            cfg_reg.crop_half_width    <= RST_CROP_HALF_W;
            cfg_reg.crop_z_low         <= RST_CROP_Z_LOW;
            cfg_reg.crop_z_high        <= RST_CROP_Z_HIGH;
            cfg_reg.match_threshold_sq <= RST_MATCH_THR;
            cfg_reg.min_votes          <= RST_MIN_VOTES;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_CENTRE_X:    cfg_reg.centre_x           <= cfg_data[COORD_W-1:0];
                CFG_CENTRE_Y:    cfg_reg.centre_y           <= cfg_data[COORD_W-1:0];
                CFG_CROP_HALF_W: cfg_reg.crop_half_width    <= cfg_data[HALF_W-1:0];
                CFG_CROP_Z_LOW:  cfg_reg.crop_z_low         <= cfg_data[COORD_W-1:0];
                CFG_CROP_Z_HIGH: cfg_reg.crop_z_high        <= cfg_data[COORD_W-1:0];
                CFG_MATCH_THR:   cfg_reg.match_threshold_sq <= cfg_data[THR_W-1:0];
                CFG_MIN_VOTES:   cfg_reg.min_votes          <= cfg_data[VOTE_W-1:0];
                default:         cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // classification front end
    pcvc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .qstat         (qstat),
        .push          (push),
        .push_ent      (push_ent)
    );

    // decoupling queue
    pcvc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .pop_ent  (pop_ent),
        .qstat    (qstat)
    );

    // voting back end
    pcvc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .qstat         (qstat),
        .pop_ent       (pop_ent),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire
